/* rtl/core/lru_block_cache_directory_macros.svh */
// ---------------------------------------------------------------------------
// LRU block cache directory: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH

// Same-cycle implication.
`define LBCD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lbcd assertion failed");

// Next-cycle implication.
`define LBCD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lbcd assertion failed");

`endif

/* rtl/core/lbcd_pkg.sv */
// ---------------------------------------------------------------------------
// LRU block cache directory: package
// Sizes, command and lower-access codes, entry type and width helpers.
// ---------------------------------------------------------------------------
package lbcd_pkg;

    localparam int SLOTS      = 64;
    localparam int BLOCK_BITS = 32;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_W      = 32;   // req_block / evicted_block port width
    localparam int IDX_W      = 6;    // slot_index port width

    typedef logic [BLOCK_BITS-1:0] tag_t;
    typedef logic [SLOT_W-1:0]     slot_id_t;

    typedef struct packed {
        tag_t     tag;
        logic     valid;
        logic     synth;
        slot_id_t id;
    } entry_t;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_SYNTH = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // lower_access codes
    localparam logic [1:0] LOW_NONE  = 2'd0;
    localparam logic [1:0] LOW_READ  = 2'd1;
    localparam logic [1:0] LOW_SYNTH = 2'd2;
    localparam logic [1:0] LOW_WRITE = 2'd3;

    function automatic tag_t num_to_tag(input logic [NUM_W-1:0] num);
        tag_t t;
        t = '0;
        for (int i = 0; i < BLOCK_BITS; i++)
        begin
            if (i < NUM_W)
            begin
                t[i] = num[i];
            end
        end
        return t;
    endfunction

    function automatic logic [NUM_W-1:0] tag_to_num(input tag_t t);
        logic [NUM_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_W; i++)
        begin
            if (i < BLOCK_BITS)
            begin
                n[i] = t[i];
            end
        end
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] id_to_index(input slot_id_t id);
        logic [IDX_W-1:0] x;
        x = '0;
        for (int i = 0; i < IDX_W; i++)
        begin
            if (i < SLOT_W)
            begin
                x[i] = id[i];
            end
        end
        return x;
    endfunction

endpackage

/* rtl/core/lbcd_cell.sv */
// ---------------------------------------------------------------------------
// LRU block cache directory: recency cell
// One position of the recency chain; loads its upper neighbor on shift.
// ---------------------------------------------------------------------------
module lbcd_cell
    import lbcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  slot_id_t init_id,     // slot held at this position after reset
    input  logic     shift_en,
    input  entry_t   prev_entry,  // more recent neighbor (or promoted entry)
    input  tag_t     lookup_tag,
    output entry_t   entry,
    output logic     match
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = shift_en ? prev_entry : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{tag: '0, valid: 1'b0, synth: 1'b0, id: init_id};
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign match = entry_reg.valid && (entry_reg.tag == lookup_tag);

endmodule

/* rtl/core/lru_block_cache_directory.sv */
// ---------------------------------------------------------------------------
// LRU block cache directory: top level
// Fully associative write-through block directory with LRU replacement.
// ---------------------------------------------------------------------------
// A request passes a compare state and then an update state. The compare
// state checks the block number against every cell of the recency chain
// and registers the match vector; once the response register is free or
// draining, the update state shifts the chain, loads the response register
// and accepts the next request, whose compare thus sees the updated order.
// The chain keeps slots sorted by recency, most recent at position 0 and
// least recent at the far end; each cell carries its slot number, tag, valid
// and synthetic marks. A hit pulls its entry to position 0 and the cells
// above it move down one place; a miss reuses the entry at the far end (its
// block is reported as evicted when valid) and the whole chain moves down.
// A CMD_NONE request leaves the chain as it is. Reset empties all slots and
// sets slot 0 least recent, slot SLOTS-1 most recent. The response register
// lets a new request be taken while the previous response waits for transfer.
// ---------------------------------------------------------------------------
`include "lru_block_cache_directory_macros.svh"

module lru_block_cache_directory
    import lbcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        command,
    input  logic [NUM_W-1:0]  req_block,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              hit,
    output logic [IDX_W-1:0]  slot_index,
    output logic              evicted,
    output logic [NUM_W-1:0]  evicted_block,
    output logic [1:0]        lower_access
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // control
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             req_xfer;
    logic             upd_go;
    logic             do_update;

    // request and lookup
    logic [1:0]       cmd_reg;
    tag_t             num_reg;
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] match_reg;
    logic [SLOTS-1:0] match_next;

    // chain
    entry_t           entries [SLOTS];
    logic [SLOTS-1:0] shift_en;
    entry_t           promo;

    // decode of the update cycle
    logic             any_hit;
    slot_id_t         hit_id;
    logic             hit_synth;
    entry_t           lru;
    logic             cmd_ok;

    // response register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_hit_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_evicted_reg;
    logic [NUM_W-1:0] out_evblk_reg;
    logic [1:0]       out_lower_reg;
    logic [IDX_W-1:0] rsp_index;
    logic             rsp_evicted;
    logic [NUM_W-1:0] rsp_evblk;
    logic [1:0]       rsp_lower;

    // update fires when the response register is free or draining
    assign upd_go    = (state_reg == ST_UPD) && (!out_valid_reg || rsp_ready);
    assign req_ready = (state_reg == ST_IDLE) || upd_go;
    assign req_xfer  = req_valid && req_ready;
    assign cmd_ok    = (cmd_reg != CMD_NONE);
    assign do_update = upd_go && cmd_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = req_xfer ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture; block number fitted to the tag width
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            cmd_reg <= command;
            num_reg <= num_to_tag(req_block);
        end
    end

    // match vector sampled at the end of the compare cycle
    assign match_next = (state_reg == ST_LOOK) ? match : match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // Hit entry pick: at most one cell matches since a block is only
    // installed on a miss.
    always_comb
    begin
        hit_id    = '0;
        hit_synth = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            hit_id    = hit_id | (match_reg[k] ? entries[k].id : '0);
            hit_synth = hit_synth | (match_reg[k] & entries[k].synth);
        end
    end

    assign any_hit = |match_reg;
    assign lru     = entries[SLOTS-1];

    // entry that lands at the most recent position
    always_comb
    begin
        promo.tag   = num_reg;
        promo.valid = 1'b1;
        if (any_hit)
        begin
            promo.id    = hit_id;
            promo.synth = (cmd_reg == CMD_READ) ? 1'b0 : hit_synth;
        end
        else
        begin
            promo.id    = lru.id;
            promo.synth = (cmd_reg == CMD_SYNTH);
        end
    end

    // the recency chain
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        // on an update a cell moves when it sits at or above the hit position, or on a miss
        assign shift_en[k] = do_update &&
                             (!any_hit || (|(match_reg & ({SLOTS{1'b1}} << k))));

        lbcd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .init_id    (SLOT_W'(SLOTS - 1 - k)),
            .shift_en   (shift_en[k]),
            .prev_entry ((k == 0) ? promo : entries[(k == 0) ? 0 : k - 1]),
            .lookup_tag (num_reg),
            .entry      (entries[k]),
            .match      (match[k])
        );
    end

    // response fields
    always_comb
    begin
        rsp_index   = '0;
        rsp_evicted = 1'b0;
        rsp_evblk   = '0;
        rsp_lower   = LOW_NONE;
        if (any_hit)
        begin
            rsp_index = id_to_index(hit_id);
        end
        else if (cmd_ok)
        begin
            rsp_index   = id_to_index(lru.id);
            rsp_evicted = lru.valid;
            rsp_evblk   = lru.valid ? tag_to_num(lru.tag) : '0;
        end
        unique case (cmd_reg)
            CMD_READ:
            begin
                rsp_lower = (!any_hit || hit_synth) ? LOW_READ : LOW_NONE;
            end
            CMD_SYNTH:
            begin
                rsp_lower = any_hit ? LOW_NONE : LOW_SYNTH;
            end
            CMD_WRITE:
            begin
                rsp_lower = LOW_WRITE;
            end
            default:
            begin
                rsp_lower = LOW_NONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            out_hit_reg     <= any_hit;
            out_index_reg   <= rsp_index;
            out_evicted_reg <= rsp_evicted;
            out_evblk_reg   <= rsp_evblk;
            out_lower_reg   <= rsp_lower;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign slot_index    = out_index_reg;
    assign evicted       = out_evicted_reg;
    assign evicted_block = out_evblk_reg;
    assign lower_access  = out_lower_reg;

    // ---- checks ----
    `LBCD_ASSERT_NOW(a_match_unique, clk, rst_n, state_reg == ST_UPD, $onehot0(match_reg))
    `LBCD_ASSERT_NOW(a_no_req_in_look, clk, rst_n, req_xfer, state_reg != ST_LOOK)
    `LBCD_ASSERT_NEXT(a_head_installed, clk, rst_n, do_update,
        entries[0].valid && (entries[0].tag == $past(num_reg)))
    `LBCD_ASSERT_NOW(a_evict_only_miss, clk, rst_n, out_valid_reg,
        !(out_hit_reg && out_evicted_reg))

endmodule
